>>> hdl/pdta_pkg.sv
// ----------------------------------------------------------------------------
// pdta_pkg
// Shared types, register map and constants of the port and dual timer adapter.
// ----------------------------------------------------------------------------
package pdta_pkg;

    // Default cap on the cycles of one tick item
    localparam int unsigned MAX_TICK_DEFAULT = 255;

    // Item commands
    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_SET_BIT = 2'd3
    } t_command;

    // Register map
    localparam logic [3:0] REG_B    = 4'd0;
    localparam logic [3:0] REG_T1CL = 4'd4;
    localparam logic [3:0] REG_T1CH = 4'd5;
    localparam logic [3:0] REG_T1LL = 4'd6;
    localparam logic [3:0] REG_T1LH = 4'd7;
    localparam logic [3:0] REG_T2CL = 4'd8;
    localparam logic [3:0] REG_T2CH = 4'd9;
    localparam logic [3:0] REG_ACR  = 4'd11;
    localparam logic [3:0] REG_IFR  = 4'd13;
    localparam logic [3:0] REG_IER  = 4'd14;
    localparam logic [3:0] REG_A    = 4'd15;

    // Flag bits and control bits
    localparam logic [7:0] FLAG_T1     = 8'h02;
    localparam logic [7:0] FLAG_T2     = 8'h20;
    localparam int unsigned ACR_FREE_RUN = 6;
    localparam int unsigned OVERLAY_BIT  = 4;

    typedef logic [7:0] t_reg_file [16];

    localparam t_reg_file REG_FILE_RESET = '{
        0: 8'h8f, 2: 8'h87, 3: 8'h7f, 15: 8'h7b, default: 8'h00
    };

    // Input item
    typedef struct packed {
        t_command   command;
        logic [3:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] tick_cycles;
        logic [3:0] bit_position;
        logic       bit_level;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_active;
        logic [7:0] port_a_value;
        logic [7:0] port_b_value;
        logic       port_a_changed;
        logic       overlay_on;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic reload;
        logic finish;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic wrap;
        logic out_free;
    } t_dp_status;

endpackage

>>> hdl/pdta_stream_if.sv
// ----------------------------------------------------------------------------
// pdta_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface pdta_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pdta_ctrl.sv
// ----------------------------------------------------------------------------
// pdta_ctrl
// Sequencer: accept an item, execute it, run the timer 1 reload loop, then
// hand the result to the output register.
// ----------------------------------------------------------------------------
module pdta_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  pdta_pkg::t_dp_status   i_status,
    output pdta_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RELOAD,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RELOAD;
            end
            S_RELOAD: begin
                if (!i_status.wrap) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands from state
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.reload  = (r_state == S_RELOAD);
        o_cmd.finish  = (r_state == S_FINISH);
    end

endmodule

>>> hdl/pdta_dpath.sv
// ----------------------------------------------------------------------------
// pdta_dpath
// Register file, timers, interrupt logic and the result register.
// ----------------------------------------------------------------------------
module pdta_dpath #(
    parameter int unsigned MAX_TICK = pdta_pkg::MAX_TICK_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdta_pkg::t_ctrl_cmd   i_cmd,
    output pdta_pkg::t_dp_status  o_status,
    input  pdta_pkg::t_in_item    i_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pdta_pkg::t_out_item   o_out_item
);

    localparam logic [15:0] TickCap = 16'(MAX_TICK);

    // State
    pdta_pkg::t_reg_file r_regs;
    pdta_pkg::t_reg_file n_regs;
    logic [6:0]          r_ier,      n_ier;
    logic [16:0]         r_t1_count, n_t1_count;
    logic [15:0]         r_t1_latch, n_t1_latch;
    logic                r_t1_run,   n_t1_run;
    logic [15:0]         r_t2_count, n_t2_count;
    logic                r_t2_run,   n_t2_run;
    logic [17:0]         r_acc,      n_acc;
    logic                r_wrap,     n_wrap;
    pdta_pkg::t_in_item  r_item;
    pdta_pkg::t_out_item r_out,      n_out;
    logic                r_out_valid;

    logic [7:0]  cyc;
    logic [16:0] reload_val;
    logic [17:0] t1_diff;
    logic [17:0] t1_sum;
    logic        t1_expired;
    logic        t1_settled;
    logic [15:0] t2_diff;
    logic        irq;
    logic [7:0]  read_val;
    logic        out_free;
    logic [15:0] new_latch;

    // Cap the tick length
    assign cyc = ({8'd0, r_item.tick_cycles} > TickCap) ? TickCap[7:0] : r_item.tick_cycles;

    // Timer 1 reload value: a latch of zero counts as 0x10000
    assign reload_val = {(r_t1_latch == 16'd0), r_t1_latch};

    // Timer 1 count after the tick, and one reload step
    assign t1_diff    = {1'b0, r_t1_count} - {10'd0, cyc};
    assign t1_expired = t1_diff[17] || (t1_diff == 18'd0);
    assign t1_sum     = r_acc + {1'b0, reload_val};
    assign t1_settled = !t1_sum[17] && (t1_sum != 18'd0);

    assign t2_diff = r_t2_count - {8'd0, cyc};

    // Interrupt and read value
    assign irq = |(r_regs[pdta_pkg::REG_IFR][6:0] & r_ier);

    always_comb begin
        case (r_item.reg_index)
            pdta_pkg::REG_IFR: read_val = r_regs[pdta_pkg::REG_IFR] | {irq, 7'd0};
            pdta_pkg::REG_IER: read_val = {1'b1, r_ier};
            default:           read_val = r_regs[r_item.reg_index];
        endcase
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign new_latch = {r_item.write_data, r_t1_latch[7:0]};

    // Next state of registers and timers
    always_comb begin
        n_regs     = r_regs;
        n_ier      = r_ier;
        n_t1_count = r_t1_count;
        n_t1_latch = r_t1_latch;
        n_t1_run   = r_t1_run;
        n_t2_count = r_t2_count;
        n_t2_run   = r_t2_run;
        n_acc      = r_acc;
        n_wrap     = r_wrap;

        // Execute the captured item
        if (i_cmd.exec) begin
            case (r_item.command)
                pdta_pkg::CMD_WRITE: begin
                    case (r_item.reg_index)
                        pdta_pkg::REG_IFR: begin
                            n_regs[pdta_pkg::REG_IFR] =
                                r_regs[pdta_pkg::REG_IFR] & ~r_item.write_data;
                        end
                        pdta_pkg::REG_IER: begin
                            if (r_item.write_data[7]) begin
                                n_ier = r_ier | r_item.write_data[6:0];
                            end else begin
                                n_ier = r_ier & ~r_item.write_data[6:0];
                            end
                        end
                        default: begin
                            n_regs[r_item.reg_index] = r_item.write_data;
                            if (r_item.reg_index == pdta_pkg::REG_T1CL ||
                                r_item.reg_index == pdta_pkg::REG_T1LL) begin
                                n_t1_latch[7:0] = r_item.write_data;
                            end
                            if (r_item.reg_index == pdta_pkg::REG_T1CH ||
                                r_item.reg_index == pdta_pkg::REG_T1LH) begin
                                n_t1_latch[15:8] = r_item.write_data;
                            end
                            // Start timer 1 from the new latch
                            if (r_item.reg_index == pdta_pkg::REG_T1CH) begin
                                n_t1_count = {(new_latch == 16'd0), new_latch};
                                n_t1_run   = 1'b1;
                                n_regs[pdta_pkg::REG_IFR] =
                                    r_regs[pdta_pkg::REG_IFR] & ~pdta_pkg::FLAG_T1;
                            end
                            if (r_item.reg_index == pdta_pkg::REG_T2CL) begin
                                n_regs[pdta_pkg::REG_IFR] =
                                    r_regs[pdta_pkg::REG_IFR] & ~pdta_pkg::FLAG_T2;
                            end
                            // Start timer 2 from the two counter bytes
                            if (r_item.reg_index == pdta_pkg::REG_T2CH) begin
                                n_t2_count = {r_item.write_data,
                                              r_regs[pdta_pkg::REG_T2CL]};
                                n_t2_run   = 1'b1;
                                n_regs[pdta_pkg::REG_IFR] =
                                    r_regs[pdta_pkg::REG_IFR] & ~pdta_pkg::FLAG_T2;
                            end
                        end
                    endcase
                end
                pdta_pkg::CMD_TICK: begin
                    if (cyc != 8'd0) begin
                        // Timer 1
                        if (r_t1_run) begin
                            if (t1_expired) begin
                                n_regs[pdta_pkg::REG_IFR] =
                                    n_regs[pdta_pkg::REG_IFR] | pdta_pkg::FLAG_T1;
                                if (r_regs[pdta_pkg::REG_ACR][pdta_pkg::ACR_FREE_RUN]) begin
                                    // Free run: reload loop finishes the count
                                    n_acc  = t1_diff;
                                    n_wrap = 1'b1;
                                end else begin
                                    n_t1_count                 = 17'd0;
                                    n_t1_run                   = 1'b0;
                                    n_regs[pdta_pkg::REG_T1CL] = 8'd0;
                                    n_regs[pdta_pkg::REG_T1CH] = 8'd0;
                                end
                            end else begin
                                n_t1_count                 = t1_diff[16:0];
                                n_regs[pdta_pkg::REG_T1CL] = t1_diff[7:0];
                                n_regs[pdta_pkg::REG_T1CH] = t1_diff[15:8];
                            end
                        end
                        // Timer 2
                        if (r_t2_run) begin
                            if (r_t2_count > {8'd0, cyc}) begin
                                n_t2_count                 = t2_diff;
                                n_regs[pdta_pkg::REG_T2CL] = t2_diff[7:0];
                                n_regs[pdta_pkg::REG_T2CH] = t2_diff[15:8];
                            end else begin
                                n_t2_count                 = 16'd0;
                                n_t2_run                   = 1'b0;
                                n_regs[pdta_pkg::REG_T2CL] = 8'd0;
                                n_regs[pdta_pkg::REG_T2CH] = 8'd0;
                                n_regs[pdta_pkg::REG_IFR]  =
                                    n_regs[pdta_pkg::REG_IFR] | pdta_pkg::FLAG_T2;
                            end
                        end
                    end
                end
                pdta_pkg::CMD_SET_BIT: begin
                    if (!r_item.bit_position[3]) begin
                        n_regs[pdta_pkg::REG_B][r_item.bit_position[2:0]] = r_item.bit_level;
                    end
                end
                default: begin
                    // Reads change no state
                end
            endcase
        end

        // Add the reload once per cycle until the count is positive
        if (i_cmd.reload && r_wrap) begin
            if (t1_settled) begin
                n_t1_count                 = t1_sum[16:0];
                n_regs[pdta_pkg::REG_T1CL] = t1_sum[7:0];
                n_regs[pdta_pkg::REG_T1CH] = t1_sum[15:8];
                n_wrap                     = 1'b0;
            end else begin
                n_acc = t1_sum;
            end
        end
    end

    // Build the result from the state after the item
    always_comb begin
        n_out.read_data      = (r_item.command == pdta_pkg::CMD_READ) ? read_val : 8'd0;
        n_out.irq_active     = irq;
        n_out.port_a_value   = r_regs[pdta_pkg::REG_A];
        n_out.port_b_value   = r_regs[pdta_pkg::REG_B];
        n_out.port_a_changed = (r_item.command == pdta_pkg::CMD_WRITE) &&
                               (r_item.reg_index == pdta_pkg::REG_A);
        n_out.overlay_on     = r_regs[pdta_pkg::REG_A][pdta_pkg::OVERLAY_BIT];
    end

    // Hold control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= pdta_pkg::REG_FILE_RESET;
            r_ier       <= 7'd0;
            r_t1_count  <= 17'd0;
            r_t1_latch  <= 16'd0;
            r_t1_run    <= 1'b0;
            r_t2_count  <= 16'd0;
            r_t2_run    <= 1'b0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_regs     <= n_regs;
            r_ier      <= n_ier;
            r_t1_count <= n_t1_count;
            r_t1_latch <= n_t1_latch;
            r_t1_run   <= n_t1_run;
            r_t2_count <= n_t2_count;
            r_t2_run   <= n_t2_run;
            r_wrap     <= n_wrap;
            if (i_cmd.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.finish && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_status.wrap     = r_wrap;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

endmodule

>>> hdl/io_port_dual_timer_adapter.sv
// ----------------------------------------------------------------------------
// io_port_dual_timer_adapter
// Interface adapter with sixteen byte registers, two down-counting timers and
// interrupt flag/enable logic, driven by one item per bus access, tick or port B bit set.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. An item passes through the steps accept,
// execute, reload check and result before its result stands in the output
// register. When a tick expires timer 1 in free-run mode, the reload adder
// adds the reload value once per cycle until the count is positive. The output
// register frees the input side: the next item is taken while a result still
// waits, and only a second finished result waits for the first to be taken.
module io_port_dual_timer_adapter #(
    parameter int unsigned MAX_TICK = pdta_pkg::MAX_TICK_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdta_stream_if.sink   i_item,
    pdta_stream_if.source o_result
);

    pdta_pkg::t_ctrl_cmd  cmd;
    pdta_pkg::t_dp_status status;
    logic                 in_ready;
    logic                 out_valid;
    pdta_pkg::t_out_item  out_item;

    // Sequencer
    pdta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Registers, timers and result
    pdta_dpath #(
        .MAX_TICK (MAX_TICK)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_item.data),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_out_item  (out_item)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.data  = out_item;

endmodule
